[design/tium_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tium_pkg
// Shared types and constants for the tandem interval union mask unit.
// ----------------------------------------------------------------------------
package tium_pkg;

  localparam int POS_BITS      = 20;
  localparam int MINLEN_BITS   = 20;
  localparam int FUZZ_BITS     = 10;
  localparam int OFS_BITS      = 40;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;
  localparam int OFS_SHIFT     = 3;  // 8 bytes per interval

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FUZZ_LIMIT = 2'd1;

  localparam logic [MINLEN_BITS-1:0] MIN_LENGTH_RST = 20'd500;
  localparam logic [FUZZ_BITS-1:0]   FUZZ_LIMIT_RST = 10'd20;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_EOP    = 1'b1;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [1:0]          chain_op_t;

  localparam chain_op_t OP_HOLD = 2'd0;
  localparam chain_op_t OP_INS  = 2'd1;
  localparam chain_op_t OP_ROT  = 2'd2;

  typedef struct packed {
    chain_op_t op;
    logic      occ;
    logic      last;
  } cell_ctl_t;

  typedef struct packed {
    logic kind;
    pos_t a_begin;
    pos_t a_end;
    pos_t b_begin;
    pos_t b_end;
  } in_item_t;

  typedef struct packed {
    pos_t                mask_begin;
    pos_t                mask_end;
    logic                interval_valid;
    logic                last_of_pile;
    logic                overflow;
    logic [OFS_BITS-1:0] track_offset;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] wdata;
  } cfg_item_t;

endpackage
`default_nettype wire

[design/tium_chan_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tium_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface tium_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/tium_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tium_cell
// One slot of a sorted chain: sorted insert from the left, rotate from the right.
// ----------------------------------------------------------------------------
module tium_cell (
  input  wire logic              clk,
  input  wire tium_pkg::cell_ctl_t ctl,
  input  wire tium_pkg::pos_t    v_in,
  input  wire tium_pkg::pos_t    left_val,
  input  wire logic              left_gt,
  input  wire tium_pkg::pos_t    right_val,
  input  wire tium_pkg::pos_t    head_val,
  output tium_pkg::pos_t         val,
  output logic                   gt
);

  tium_pkg::pos_t val_r, val_nxt;

  // empty slots act as +infinity
  assign gt  = !ctl.occ || (val_r > v_in);
  assign val = val_r;

  always_comb begin
    case (ctl.op)
      tium_pkg::OP_INS: val_nxt = left_gt ? left_val : (gt ? v_in : val_r);
      tium_pkg::OP_ROT: val_nxt = ctl.last ? head_val : right_val;
      default:          val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

[design/tium_chain.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tium_chain
// Row of cells holding one sorted store; head is the smallest occupied entry.
// ----------------------------------------------------------------------------
module tium_chain #(
  parameter int N  = 64,
  parameter int CW = $clog2(N + 1)
) (
  input  wire logic                clk,
  input  wire tium_pkg::chain_op_t op,
  input  wire logic [CW-1:0]       count,
  input  wire tium_pkg::pos_t      v_in,
  output tium_pkg::pos_t           head
);

  tium_pkg::pos_t      val [N];
  logic                gt  [N];
  tium_pkg::cell_ctl_t ctl [N];

  assign head = val[0];

  for (genvar k = 0; k < N; k++) begin : g_cell
    tium_pkg::pos_t left_val, right_val;
    logic           left_gt;

    if (k == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = val[k-1];
      assign left_gt  = gt[k-1];
    end

    if (k == N - 1) begin : g_last
      assign right_val = val[k];
    end else begin : g_nlast
      assign right_val = val[k+1];
    end

    assign ctl[k].op   = op;
    assign ctl[k].occ  = CW'(k) < count;
    assign ctl[k].last = count == CW'(k + 1);

    tium_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[k]),
      .v_in      (v_in),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .head_val  (val[0]),
      .val       (val[k]),
      .gt        (gt[k])
    );
  end

endmodule
`default_nettype wire

[design/tandem_interval_union_mask_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tandem_interval_union_mask_unit
// Collects self-alignment records of one read and emits the merged mask.
// ----------------------------------------------------------------------------
// in_s  : one beat per record (kind 0) or end of pile (kind 1). A record is
//         taken at its handshake: qualifying starts and ends are inserted into two
//         sorted cell chains in parallel. Beyond MAX_INTERVALS entries a
//         record is dropped and the pile's overflow flag is set.
// out_s : after end of a non-empty pile the unit runs a counting sweep over
//         both chains (one chain rotation per cycle), updates the track
//         offset, then runs an emitting sweep that writes one beat per
//         merged interval into the output register. An empty pile gives
//         one beat with interval_valid low. in_s is not ready from end of
//         pile until the last beat is loaded.
// cfg_s : register writes (0 min_length, 1 fuzz_limit), always ready; the
//         user must keep them only written while idle; block does not enforce.
// A stalled receiver holds the output register and pauses the emitting
// sweep. Reset clears the count, overflow flag, offset and restores the
// register defaults; store contents are not cleared.
// ----------------------------------------------------------------------------
module tandem_interval_union_mask_unit #(
  parameter int MAX_INTERVALS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tium_chan_if.sink     in_s,
  tium_chan_if.source   out_s,
  tium_chan_if.sink     cfg_s
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int QW = tium_pkg::POS_BITS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, depth_r, depth_nxt, nres_r, nres_nxt;
  logic ovf_r, ovf_nxt;
  logic [tium_pkg::OFS_BITS-1:0] offset_r, offset_nxt;
  logic [tium_pkg::MINLEN_BITS-1:0] min_length_r;
  logic [tium_pkg::FUZZ_BITS-1:0] fuzz_limit_r;
  tium_pkg::pos_t open_at_r, open_at_nxt;
  logic out_valid_r, out_valid_nxt;
  tium_pkg::out_item_t out_data_r, out_data_nxt, res;
  logic out_load;

  tium_pkg::chain_op_t start_op, end_op;
  tium_pkg::pos_t s_head, e_head;

  logic in_ready, in_fire, qualify, pick_start, closes, out_free, last_end;
  logic [CW-1:0] depth_dec, nres_inc;

  assign in_ready    = state_r == ST_IDLE;
  assign in_s.ready  = in_ready;
  assign in_fire     = in_s.valid && in_ready;
  assign cfg_s.ready = 1'b1;
  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

  assign qualify =
    ({1'b0, in_s.data.a_begin} <= ({1'b0, in_s.data.b_end} + QW'(fuzz_limit_r))) &&
    ({1'b0, in_s.data.a_end} > ({1'b0, in_s.data.b_begin} + QW'(min_length_r)));

  assign pick_start = (i_r < count_r) && (s_head <= e_head);
  assign depth_dec  = depth_r - CW'(depth_r != '0);
  assign closes     = !pick_start && (depth_dec == '0);
  assign nres_inc   = nres_r + CW'(closes);
  assign last_end   = !pick_start && (j_r == count_r - CW'(1));
  assign out_free   = !out_valid_r || out_s.ready;

  tium_chain #(.N(MAX_INTERVALS), .CW(CW)) u_start_chain (
    .clk   (clk),
    .op    (start_op),
    .count (count_r),
    .v_in  (in_s.data.b_begin),
    .head  (s_head)
  );

  tium_chain #(.N(MAX_INTERVALS), .CW(CW)) u_end_chain (
    .clk   (clk),
    .op    (end_op),
    .count (count_r),
    .v_in  (in_s.data.a_end),
    .head  (e_head)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    depth_nxt   = depth_r;
    nres_nxt    = nres_r;
    ovf_nxt     = ovf_r;
    offset_nxt  = offset_r;
    open_at_nxt = open_at_r;
    start_op    = tium_pkg::OP_HOLD;
    end_op      = tium_pkg::OP_HOLD;
    out_load    = 1'b0;
    res.mask_begin     = open_at_r;
    res.mask_end       = e_head;
    res.interval_valid = 1'b1;
    res.last_of_pile   = last_end;
    res.overflow       = ovf_r;
    res.track_offset   = offset_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_s.data.kind == tium_pkg::KIND_RECORD) begin
            if (qualify) begin
              if (count_r == CW'(MAX_INTERVALS)) begin
                ovf_nxt = 1'b1;
              end else begin
                start_op  = tium_pkg::OP_INS;
                end_op    = tium_pkg::OP_INS;
                count_nxt = count_r + CW'(1);
              end
            end
          end else begin
            i_nxt     = '0;
            j_nxt     = '0;
            depth_nxt = '0;
            nres_nxt  = '0;
            state_nxt = (count_r == '0) ? ST_EMIT : ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (pick_start) begin
          start_op  = tium_pkg::OP_ROT;
          i_nxt     = i_r + CW'(1);
          depth_nxt = depth_r + CW'(1);
        end else begin
          end_op    = tium_pkg::OP_ROT;
          j_nxt     = j_r + CW'(1);
          depth_nxt = depth_dec;
          nres_nxt  = nres_inc;
          if (last_end) begin
            offset_nxt = offset_r +
              (tium_pkg::OFS_BITS'(nres_inc) << tium_pkg::OFS_SHIFT);
            i_nxt     = '0;
            j_nxt     = '0;
            depth_nxt = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (count_r == '0) begin
            out_load           = 1'b1;
            res.mask_begin     = '0;
            res.mask_end       = '0;
            res.interval_valid = 1'b0;
            res.last_of_pile   = 1'b1;
            count_nxt          = '0;
            ovf_nxt            = 1'b0;
            state_nxt          = ST_IDLE;
          end else if (pick_start) begin
            start_op  = tium_pkg::OP_ROT;
            i_nxt     = i_r + CW'(1);
            depth_nxt = depth_r + CW'(1);
            if (depth_r == '0) begin
              open_at_nxt = s_head;
            end
          end else begin
            end_op    = tium_pkg::OP_ROT;
            j_nxt     = j_r + CW'(1);
            depth_nxt = depth_dec;
            out_load  = closes;
            if (last_end) begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_data_nxt  = out_load ? res : out_data_r;
    out_valid_nxt = out_load || (out_valid_r && !out_s.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      depth_r      <= '0;
      nres_r       <= '0;
      ovf_r        <= 1'b0;
      offset_r     <= '0;
      out_valid_r  <= 1'b0;
      min_length_r <= tium_pkg::MIN_LENGTH_RST;
      fuzz_limit_r <= tium_pkg::FUZZ_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      depth_r     <= depth_nxt;
      nres_r      <= nres_nxt;
      ovf_r       <= ovf_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_s.valid) begin
        case (cfg_s.data.index)
          tium_pkg::CFG_MIN_LENGTH:
            min_length_r <= cfg_s.data.wdata[tium_pkg::MINLEN_BITS-1:0];
          tium_pkg::CFG_FUZZ_LIMIT:
            fuzz_limit_r <= cfg_s.data.wdata[tium_pkg::FUZZ_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    open_at_r  <= open_at_nxt;
    out_data_r <= out_data_nxt;
  end

  a_eop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_s.data.kind == tium_pkg::KIND_EOP) |=> (state_r != ST_IDLE))
    else $error("end of pile did not start the sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_INTERVALS))
    else $error("store count beyond depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res.last_of_pile) |=> (state_r == ST_IDLE && count_r == '0 && !ovf_r))
    else $error("pile state not cleared after last beat");

  a_sweep_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && count_r != '0) |-> (j_r < count_r && i_r <= count_r))
    else $error("sweep index out of range");

endmodule
`default_nettype wire
